@@ hdl/mfu_page_frame_policy_core_assert.svh @@
// Assertion macros for the MFU page frame policy core checker.
`ifndef MFU_PAGE_FRAME_POLICY_CORE_ASSERT_SVH
`define MFU_PAGE_FRAME_POLICY_CORE_ASSERT_SVH

// Same-cycle implication.
`define MFU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfu check failed");

// Delayed implication of the consequent on the antecedent.
`define MFU_ASSERT_AFTER2(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("mfu latency check failed");

`endif

@@ hdl/mfu_pkg.sv @@
// Shared constants and types for the MFU page frame policy core.
package mfu_pkg;

  localparam int NUM_FRAMES   = 6;
  localparam int OFFSET_BITS  = 8;
  localparam int FRAME_WORDS  = 1 << OFFSET_BITS;
  localparam int SLOT_W       = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  localparam int INDEX_W      = 24;
  localparam int PAGE_W       = 16;
  localparam int USE_W        = 32;
  localparam int OFFSET_OUT_W = 8;
  localparam int SLOT_OUT_W   = 3;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [USE_W-1:0]  uses_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic  hit;
    logic  evict;
    slot_t slot;
  } decision_t;

endpackage

@@ hdl/mfu_page_frame_policy_core.sv @@
// Top level of the MFU page frame policy core.
//
//   channel  | handshake       | payload
//   ---------+-----------------+---------------------------------------------------
//   request  | start / busy    | element_index
//   result   | done (strobe)   | hit, frame_slot, page_offset, fill_needed,
//            |                 | evict_valid, evicted_page
//
// One request per cycle; busy is always low.
// Each request is registered in the input register, then passes once through
// the frame lookup into the result register and the frame table.
// rst clears the valid bits and the pipeline strobes; all frames start empty.
// The receiver takes every result in its strobe cycle; nothing is held back.
module mfu_page_frame_policy_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [mfu_pkg::INDEX_W-1:0]         element_index,
  output logic                                done,
  output logic                                hit,
  output logic [mfu_pkg::SLOT_OUT_W-1:0]      frame_slot,
  output logic [mfu_pkg::OFFSET_OUT_W-1:0]    page_offset,
  output logic                                fill_needed,
  output logic                                evict_valid,
  output logic [mfu_pkg::PAGE_W-1:0]          evicted_page
);

  logic                          req_valid;
  logic [mfu_pkg::INDEX_W-1:0]   req_index;
  logic [mfu_pkg::INDEX_W-1:0]   req_shifted;
  logic [mfu_pkg::INDEX_W-1:0]   req_masked;
  mfu_pkg::page_t                req_page;
  mfu_pkg::decision_t            decision;
  logic [mfu_pkg::NUM_FRAMES-1:0] valid;
  mfu_pkg::page_t                pages [mfu_pkg::NUM_FRAMES];
  mfu_pkg::uses_t                uses  [mfu_pkg::NUM_FRAMES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_index <= element_index;
    end
  end

  assign req_shifted = req_index >> mfu_pkg::OFFSET_BITS;
  assign req_masked  = req_index & mfu_pkg::INDEX_W'(mfu_pkg::FRAME_WORDS - 1);
  assign req_page    = req_shifted[mfu_pkg::PAGE_W-1:0];

  mfu_select u_select (
    .valid    (valid),
    .pages    (pages),
    .uses     (uses),
    .page     (req_page),
    .decision (decision)
  );

  mfu_frame_table u_frame_table (
    .clk      (clk),
    .rst      (rst),
    .update   (req_valid),
    .decision (decision),
    .page     (req_page),
    .valid    (valid),
    .pages    (pages),
    .uses     (uses)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      hit          <= decision.hit;
      frame_slot   <= mfu_pkg::SLOT_OUT_W'(decision.slot);
      page_offset  <= req_masked[mfu_pkg::OFFSET_OUT_W-1:0];
      fill_needed  <= !decision.hit;
      evict_valid  <= decision.evict;
      evicted_page <= decision.evict ? pages[decision.slot] : '0;
    end
  end

endmodule

@@ hdl/mfu_select.sv @@
// Frame lookup: hit search, lowest free frame and most-used victim pick.
module mfu_select (
  input  logic                  [mfu_pkg::NUM_FRAMES-1:0] valid,
  input  mfu_pkg::page_t                                  pages [mfu_pkg::NUM_FRAMES],
  input  mfu_pkg::uses_t                                  uses  [mfu_pkg::NUM_FRAMES],
  input  mfu_pkg::page_t                                  page,
  output mfu_pkg::decision_t                              decision
);

  logic           hit_found;
  mfu_pkg::slot_t hit_slot;
  logic           free_found;
  mfu_pkg::slot_t free_slot;
  mfu_pkg::slot_t best_slot;

  always_comb begin
    hit_found  = 1'b0;
    hit_slot   = '0;
    free_found = 1'b0;
    free_slot  = '0;
    for (int k = 0; k < mfu_pkg::NUM_FRAMES; k++) begin
      if (!hit_found && valid[k] && (pages[k] == page)) begin
        hit_found = 1'b1;
        hit_slot  = mfu_pkg::SLOT_W'(k);
      end
      if (!free_found && !valid[k]) begin
        free_found = 1'b1;
        free_slot  = mfu_pkg::SLOT_W'(k);
      end
    end
  end

  // first frame holding the highest use count
  always_comb begin
    best_slot = '0;
    for (int k = 1; k < mfu_pkg::NUM_FRAMES; k++) begin
      if (uses[k] > uses[best_slot]) begin
        best_slot = mfu_pkg::SLOT_W'(k);
      end
    end
  end

  always_comb begin
    decision.hit   = hit_found;
    decision.evict = !hit_found && !free_found;
    if (hit_found) begin
      decision.slot = hit_slot;
    end else if (free_found) begin
      decision.slot = free_slot;
    end else begin
      decision.slot = best_slot;
    end
  end

endmodule

@@ hdl/mfu_frame_table.sv @@
// Frame table: valid bits, resident pages and saturating use counts.
module mfu_frame_table (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     update,
  input  mfu_pkg::decision_t                       decision,
  input  mfu_pkg::page_t                           page,
  output logic           [mfu_pkg::NUM_FRAMES-1:0] valid,
  output mfu_pkg::page_t                           pages [mfu_pkg::NUM_FRAMES],
  output mfu_pkg::uses_t                           uses  [mfu_pkg::NUM_FRAMES]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (update && !decision.hit) begin
      valid[decision.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < mfu_pkg::NUM_FRAMES; k++) begin
        pages[k] <= '0;
        uses[k]  <= '0;
      end
    end else if (update) begin
      if (decision.hit) begin
        if (uses[decision.slot] != '1) begin
          uses[decision.slot] <= uses[decision.slot] + mfu_pkg::USE_W'(1);
        end
      end else begin
        pages[decision.slot] <= page;
        uses[decision.slot]  <= '0;
      end
    end
  end

endmodule

@@ hdl/mfu_page_frame_policy_core_checker.sv @@
// Port-level checker for the MFU page frame policy core, with its bind.
`include "mfu_page_frame_policy_core_assert.svh"

module mfu_page_frame_policy_core_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic                             hit,
  input logic [mfu_pkg::SLOT_OUT_W-1:0]   frame_slot,
  input logic                             fill_needed,
  input logic                             evict_valid,
  input logic [mfu_pkg::PAGE_W-1:0]       evicted_page
);

  logic hit_clean;

  assign hit_clean = !fill_needed && !evict_valid && (evicted_page == '0);

  `MFU_ASSERT_AFTER2(a_result_follows_transfer, clk, rst, start && !busy, done)
  `MFU_ASSERT_IMPLY(a_hit_is_clean, clk, rst, done && hit, hit_clean)
  `MFU_ASSERT_IMPLY(a_miss_fills, clk, rst, done && !hit, fill_needed)
  `MFU_ASSERT_IMPLY(a_slot_in_range, clk, rst, done, frame_slot < mfu_pkg::SLOT_OUT_W'(mfu_pkg::NUM_FRAMES))

endmodule

bind mfu_page_frame_policy_core mfu_page_frame_policy_core_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .hit          (hit),
  .frame_slot   (frame_slot),
  .fill_needed  (fill_needed),
  .evict_valid  (evict_valid),
  .evicted_page (evicted_page)
);
